// ===== rtl/core/postfix_expression_evaluator_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Immediate wrappers around concurrent assertions on clk_i / rst_ni; they
// compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define PFX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define PFX_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define PFX_ASSERT(lbl, prop)
`define PFX_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/pfx_pkg.sv =====
// ---------------------------------------------------------------------------
// pfx_pkg
// Shared constants, codes and controller/datapath types of the evaluator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int SYM_W       = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [SYM_W-1:0] CH_NUL     = 8'd0;
  localparam logic [SYM_W-1:0] CH_ZERO    = 8'd48;
  localparam logic [SYM_W-1:0] CH_NINE    = 8'd57;
  localparam logic [SYM_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PERCENT = 8'h25;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DECODE,
    CS_CLASS,
    CS_RD_RHS,
    CS_RD_LHS,
    CS_EXEC,
    CS_DIV,
    CS_PUSH,
    CS_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic sym_load;
    logic acc_update;
    logic push_acc;
    logic note_underflow;
    logic rd_top;
    logic rd_second;
    logic cap_rhs;
    logic cap_lhs_pop;
    logic exec_alu;
    logic div_start;
    logic div_capture;
    logic push_res;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_end;
    logic in_number;
    logic cnt_lt2;
    logic cnt_nz;
    logic div_needed;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/pfx_div.sv =====
// ---------------------------------------------------------------------------
// pfx_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfx_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pfx_pkg::DATA_W-1:0]  dividend_i,
  input  logic [pfx_pkg::DATA_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [pfx_pkg::DATA_W-1:0]  quot_o,
  output logic [pfx_pkg::DATA_W-1:0]  rem_o
);

  localparam int W = pfx_pkg::DATA_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [pfx_pkg::DIV_CNT_W-1:0] step_q, step_d;
  logic [W-1:0]                  a_q, a_d;
  logic [W-1:0]                  r_q, r_d;
  logic [W-1:0]                  b_q, b_d;
  logic                          qneg_q, qneg_d;
  logic                          rneg_q, rneg_d;

  logic [W-1:0] shifted;
  logic [W:0]   diff;
  logic         ge;

  // remainder stays below the divisor magnitude, so its top bit is clear
  assign shifted = {r_q[W-2:0], a_q[W-1]};
  assign diff    = {1'b0, shifted} - {1'b0, b_q};
  assign ge      = ~diff[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    a_d    = a_q;
    r_d    = r_q;
    b_d    = b_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = pfx_pkg::DIV_CNT_W'(pfx_pkg::DIV_STEPS);
      a_d    = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      b_d    = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
      r_d    = '0;
      qneg_d = dividend_i[W-1] ^ divisor_i[W-1];
      rneg_d = dividend_i[W-1];
    end else if (busy_q) begin
      r_d    = ge ? diff[W-1:0] : shifted;
      a_d    = {a_q[W-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == pfx_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    r_q    <= r_d;
    b_q    <= b_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? (~a_q + 1'b1) : a_q;
  assign rem_o  = rneg_q ? (~r_q + 1'b1) : r_q;

endmodule

// ===== rtl/core/pfx_dp.sv =====
// ---------------------------------------------------------------------------
// pfx_dp
// Evaluator datapath: symbol decode, number builder, operand stack, ALU,
// divider and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_top_macros.svh"

module pfx_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfx_pkg::cmd_t               cmd_i,
  output pfx_pkg::sts_t               sts_o,
  input  logic [pfx_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [pfx_pkg::DATA_W-1:0]  value_o,
  output logic [2:0]                  status_o
);

  localparam int W = pfx_pkg::DATA_W;

  logic [pfx_pkg::SYM_W-1:0] sym_q;
  logic [W-1:0]              acc_q, acc_d;
  logic                      in_num_q, in_num_d;
  logic [pfx_pkg::CNT_W-1:0] cnt_q, cnt_d;
  pfx_pkg::status_e          err_q, err_d;
  logic                      out_valid_q, out_valid_d;
  logic [W-1:0]              lhs_q, rhs_q, res_q, value_q;
  pfx_pkg::status_e          status_q;
  logic [W-1:0]              rd_q;

  logic [W-1:0] stack_mem [pfx_pkg::STACK_DEPTH];

  logic                       is_digit, is_op, is_divmod;
  logic [W-1:0]               digit, acc_x10;
  logic [W-1:0]               mul_lo, alu_res;
  logic                       has_room, wr_en;
  logic [W-1:0]               wr_data;
  logic [pfx_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [pfx_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
  logic                       div_done;
  logic [W-1:0]               div_quot, div_rem;
  pfx_pkg::status_e           end_status;

  assign is_digit  = (sym_q >= pfx_pkg::CH_ZERO) && (sym_q <= pfx_pkg::CH_NINE);
  assign is_divmod = (sym_q == pfx_pkg::CH_SLASH) || (sym_q == pfx_pkg::CH_PERCENT);
  assign is_op     = (sym_q == pfx_pkg::CH_PLUS) || (sym_q == pfx_pkg::CH_MINUS) ||
                     (sym_q == pfx_pkg::CH_STAR) || is_divmod;

  assign digit   = W'(sym_q - pfx_pkg::CH_ZERO);
  assign acc_x10 = {acc_q[W-4:0], 3'b000} + {acc_q[W-2:0], 1'b0};

  assign mul_lo = lhs_q * rhs_q;

  always_comb begin
    case (sym_q)
      pfx_pkg::CH_PLUS:  alu_res = lhs_q + rhs_q;
      pfx_pkg::CH_MINUS: alu_res = lhs_q - rhs_q;
      pfx_pkg::CH_STAR:  alu_res = mul_lo;
      default:           alu_res = '0;
    endcase
  end

  // stack addressing
  assign has_room = cnt_q < pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH);
  assign cnt_m1   = cnt_q - 1'b1;
  assign cnt_m2   = cnt_q - 2'd2;
  assign wr_addr  = cnt_q[pfx_pkg::ADDR_W-1:0];
  assign rd_addr  = cmd_i.rd_second ? cnt_m2[pfx_pkg::ADDR_W-1:0]
                                    : cnt_m1[pfx_pkg::ADDR_W-1:0];
  assign wr_en    = (cmd_i.push_acc || cmd_i.push_res) && has_room;
  assign wr_data  = cmd_i.push_acc ? acc_q : res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_top || cmd_i.rd_second) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  pfx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (lhs_q),
    .divisor_i  (rhs_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (err_q != pfx_pkg::ST_OK) begin
      end_status = err_q;
    end else if (cnt_q == '0) begin
      end_status = pfx_pkg::ST_EMPTY;
    end else begin
      end_status = pfx_pkg::ST_OK;
    end
  end

  // control state: count, accumulator, first error, result valid
  always_comb begin
    acc_d       = acc_q;
    in_num_d    = in_num_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.acc_update) begin
      acc_d    = in_num_q ? (acc_x10 + digit) : digit;
      in_num_d = 1'b1;
    end
    if (cmd_i.push_acc) begin
      acc_d    = '0;
      in_num_d = 1'b0;
    end
    if (cmd_i.push_acc || cmd_i.push_res) begin
      if (has_room) begin
        cnt_d = cnt_q + 1'b1;
      end else if (err_q == pfx_pkg::ST_OK) begin
        err_d = pfx_pkg::ST_OVERFLOW;
      end
    end
    if (cmd_i.note_underflow && (err_q == pfx_pkg::ST_OK)) begin
      err_d = pfx_pkg::ST_UNDERFLOW;
    end
    if (cmd_i.exec_alu && is_divmod && (err_q == pfx_pkg::ST_OK)) begin
      err_d = pfx_pkg::ST_DIVZERO;
    end
    if (cmd_i.cap_lhs_pop) begin
      cnt_d = cnt_m2;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      cnt_d       = '0;
      err_d       = pfx_pkg::ST_OK;
      acc_d       = '0;
      in_num_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      in_num_q    <= 1'b0;
      cnt_q       <= '0;
      err_q       <= pfx_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      in_num_q    <= in_num_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sym_load) begin
      sym_q <= symbol_i;
    end
    if (cmd_i.cap_rhs) begin
      rhs_q <= rd_q;
    end
    if (cmd_i.cap_lhs_pop) begin
      lhs_q <= rd_q;
    end
    if (cmd_i.exec_alu) begin
      res_q <= alu_res;
    end
    if (cmd_i.div_capture) begin
      res_q <= (sym_q == pfx_pkg::CH_SLASH) ? div_quot : div_rem;
    end
    if (cmd_i.emit) begin
      value_q  <= (cnt_q != '0) ? rd_q : '0;
      status_q <= end_status;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.is_digit   = is_digit;
    sts_o.is_op      = is_op;
    sts_o.is_end     = (sym_q == pfx_pkg::CH_NUL);
    sts_o.in_number  = in_num_q;
    sts_o.cnt_lt2    = cnt_q < pfx_pkg::CNT_W'(2);
    sts_o.cnt_nz     = cnt_q != '0;
    sts_o.div_needed = is_divmod && (rhs_q != '0);
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  `PFX_ASSERT(a_cnt_bound, cnt_q <= pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH))
  `PFX_ASSERT(a_wr_room, !wr_en || (cnt_q < pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH)))
  `PFX_ASSERT_NEXT(a_err_sticky, (err_q != pfx_pkg::ST_OK) && !cmd_i.emit, err_q == $past(err_q))
  `PFX_ASSERT_NEXT(a_emit_clear, cmd_i.emit, (cnt_q == '0) && out_valid_q)

endmodule

// ===== rtl/core/pfx_ctrl.sv =====
// ---------------------------------------------------------------------------
// pfx_ctrl
// Sequencer of the evaluator: steps each request through decode, stack
// access, arithmetic and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfx_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pfx_pkg::sts_t sts_i,
  output pfx_pkg::cmd_t cmd_o
);

  pfx_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfx_pkg::CS_IDLE: begin
        if (in_valid_i) state_d = pfx_pkg::CS_DECODE;
      end
      pfx_pkg::CS_DECODE: begin
        state_d = sts_i.is_digit ? pfx_pkg::CS_IDLE : pfx_pkg::CS_CLASS;
      end
      pfx_pkg::CS_CLASS: begin
        if (sts_i.is_op) begin
          state_d = sts_i.cnt_lt2 ? pfx_pkg::CS_IDLE : pfx_pkg::CS_RD_RHS;
        end else if (sts_i.is_end) begin
          state_d = pfx_pkg::CS_EMIT;
        end else begin
          state_d = pfx_pkg::CS_IDLE;
        end
      end
      pfx_pkg::CS_RD_RHS: state_d = pfx_pkg::CS_RD_LHS;
      pfx_pkg::CS_RD_LHS: state_d = pfx_pkg::CS_EXEC;
      pfx_pkg::CS_EXEC: begin
        state_d = sts_i.div_needed ? pfx_pkg::CS_DIV : pfx_pkg::CS_PUSH;
      end
      pfx_pkg::CS_DIV: begin
        if (sts_i.div_done) state_d = pfx_pkg::CS_PUSH;
      end
      pfx_pkg::CS_PUSH: state_d = pfx_pkg::CS_IDLE;
      pfx_pkg::CS_EMIT: begin
        if (sts_i.out_free) state_d = pfx_pkg::CS_IDLE;
      end
      default: state_d = pfx_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pfx_pkg::CS_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.sym_load = in_valid_i;
      end
      pfx_pkg::CS_DECODE: begin
        cmd_o.acc_update = sts_i.is_digit;
        cmd_o.push_acc   = !sts_i.is_digit && sts_i.in_number;
      end
      pfx_pkg::CS_CLASS: begin
        cmd_o.note_underflow = sts_i.is_op && sts_i.cnt_lt2;
        cmd_o.rd_top         = (sts_i.is_op && !sts_i.cnt_lt2) ||
                               (sts_i.is_end && sts_i.cnt_nz);
      end
      pfx_pkg::CS_RD_RHS: begin
        cmd_o.cap_rhs   = 1'b1;
        cmd_o.rd_second = 1'b1;
      end
      pfx_pkg::CS_RD_LHS: cmd_o.cap_lhs_pop = 1'b1;
      pfx_pkg::CS_EXEC: begin
        cmd_o.div_start = sts_i.div_needed;
        cmd_o.exec_alu  = !sts_i.div_needed;
      end
      pfx_pkg::CS_DIV:  cmd_o.div_capture = sts_i.div_done;
      pfx_pkg::CS_PUSH: cmd_o.push_res = 1'b1;
      pfx_pkg::CS_EMIT: cmd_o.emit = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfx_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/postfix_expression_evaluator_top.sv =====
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Reverse Polish evaluator over an ASCII character stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Feed one character per request on symbol_i. Digit runs build an unsigned
// number that is pushed when the next non-digit arrives; + - * / % pop two
// values and push (second-from-top op top) with 32-bit wrapping arithmetic
// and truncating division; other characters only separate tokens. A zero
// byte closes the expression and produces one result request: value_o is
// the stack top (0 if empty) and status_o is 0 ok, 1 underflow, 2 divide by
// zero, 3 overflow or 4 empty; only the first error is reported, and the
// block then starts afresh. Each character is stepped through by the
// sequencer, with the stack memory's registered read: a digit ends after
// decode, and closing a pending number adds no step, as the push rides in
// the decode state. + - * read both values, execute and push; / % also wait
// on the bit-serial divider's 32 iterations, except when the divisor is
// zero. An operator that finds fewer than two values ends after it is
// classified. A zero byte waits only while an earlier result has not yet
// been taken downstream. No clearing pass after reset.
module postfix_expression_evaluator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfx_pkg::SYM_W-1:0]   symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [pfx_pkg::DATA_W-1:0] value_o,
  output logic [2:0]                  status_o
);

  pfx_pkg::cmd_t cmd;
  pfx_pkg::sts_t sts;
  logic [pfx_pkg::DATA_W-1:0] value_raw;

  // sequencer: holds the input off while a character is in flight
  pfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: stack, arithmetic and the output register
  pfx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .symbol_i    (symbol_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_raw),
    .status_o    (status_o)
  );

  assign value_o = $signed(value_raw);

endmodule

// ===== tb/postfix_expression_evaluator_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_top_test
// Self-checking bench for the reverse Polish evaluator. Characters are fed
// through the request handshake in bursts with random gaps, and results are
// drained under a shifting stall pattern. A behavioural copy of the
// evaluator predicts every result. A short table of hand-picked expressions
// comes first. Random expressions follow: mostly well-formed, some broken,
// some noise, and a few deep enough to fill the stack.
// ---------------------------------------------------------------------------

module postfix_expression_evaluator_top_test;
  import pfx_pkg::*;

  // One result of a finished expression, as the block should report it
  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
  } expr_result_t;

  localparam int DIR_ROWS      = 7;
  localparam int RANDOM_TARGET = 1200;  // characters to send in all
  localparam int SETTLE_CYCLES = 100;   // longer than the slowest character

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [SYM_W-1:0]         symbol_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] value_o;
  logic [2:0]               status_o;

  postfix_expression_evaluator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Directed expressions. Each text is sent character by character and then
  // closed with a zero byte. Where the outcome is obvious it is typed in;
  // otherwise the evaluator copy below supplies it.
  //   empty expression, underflow (and the top code 255 as a separator),
  //   modulo by zero, most negative value over -1, three operators in one
  //   chain, long number wrap with a value left below the top, and a second
  //   error after a divide by zero that must not replace it.
  // -------------------------------------------------------------------------
  string dir_text [DIR_ROWS] = '{
    "",
    "\377+",
    "9 0%",
    "2147483648 4294967295/",
    "12\3775-3*7/",
    "99999999999 1+ 4",
    "8 0/+"
  };
  bit dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
  expr_result_t dir_result [DIR_ROWS] = '{
    '{32'd0,          ST_EMPTY},
    '{32'd0,          ST_UNDERFLOW},
    '{32'd0,          ST_DIVZERO},
    '{32'h8000_0000,  ST_OK},
    '{32'd0,          ST_OK},
    '{32'd0,          ST_OK},
    '{32'd0,          ST_DIVZERO}
  };

  // -------------------------------------------------------------------------
  // Behavioural evaluator: operand stack, count, digit accumulator and the
  // first error seen since the last zero byte
  // -------------------------------------------------------------------------
  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int unsigned       model_count;
  logic [DATA_W-1:0] model_acc;
  bit                model_in_number;
  status_e           model_err;

  expr_result_t expected_q [$];
  bit           typed_armed;
  expr_result_t typed_result;

  int error_count;
  int symbols_sent;
  int exprs_sent;
  int results_checked;
  int status_seen [8];
  int burst_left;

  function automatic void model_reset();
    model_count     = 0;
    model_acc       = '0;
    model_in_number = 1'b0;
    model_err       = ST_OK;
  endfunction

  // Keep only the first error of an expression
  function automatic void record_error(status_e code);
    if (model_err == ST_OK) model_err = code;
  endfunction

  // Drop the value and flag overflow when the stack is full
  function automatic void model_push(logic [DATA_W-1:0] val);
    if (model_count >= STACK_DEPTH) begin
      record_error(ST_OVERFLOW);
    end else begin
      model_stack[model_count] = val;
      model_count++;
    end
  endfunction

  // Advance the evaluator by one character; flag a result on a zero byte
  function automatic void evaluate_symbol(input logic [SYM_W-1:0] sym,
                                          output bit produced,
                                          output expr_result_t res);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] val;
    longint            a;
    longint            b;
    longint            q;
    produced = 1'b0;
    res      = '0;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      if (model_in_number) model_acc = model_acc * 32'd10 + (sym - CH_ZERO);
      else model_acc = sym - CH_ZERO;
      model_in_number = 1'b1;
      return;
    end
    // Any non-digit closes a pending number
    if (model_in_number) begin
      model_push(model_acc);
      model_in_number = 1'b0;
      model_acc       = '0;
    end
    if (sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT}) begin
      if (model_count < 2) begin
        record_error(ST_UNDERFLOW);
        return;
      end
      rhs = model_stack[model_count-1];
      lhs = model_stack[model_count-2];
      model_count -= 2;
      a = $signed(lhs);
      b = $signed(rhs);
      case (sym)
        CH_PLUS:  val = lhs + rhs;
        CH_MINUS: val = lhs - rhs;
        CH_STAR:  val = lhs * rhs;
        default: begin
          if (b == 0) begin
            record_error(ST_DIVZERO);
            val = '0;
          end else begin
            // 64-bit arithmetic so the most negative value over -1 wraps
            q   = (sym == CH_SLASH) ? a / b : a % b;
            val = q[DATA_W-1:0];
          end
        end
      endcase
      model_push(val);
      return;
    end
    if (sym != CH_NUL) return;
    res.value = (model_count > 0) ? model_stack[model_count-1] : '0;
    if (model_err != ST_OK) res.status = model_err;
    else if (model_count == 0) res.status = ST_EMPTY;
    else res.status = ST_OK;
    produced = 1'b1;
    model_reset();
  endfunction

  // -------------------------------------------------------------------------
  // Sender: hold each request until accepted; open a random gap between
  // bursts of random length
  // -------------------------------------------------------------------------
  task automatic send_symbol(input logic [SYM_W-1:0] sym);
    int           gap;
    bit           produced;
    expr_result_t res;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    do @(posedge clk_i); while (!in_ready_o);
    symbols_sent++;
    evaluate_symbol(sym, produced, res);
    if (produced) begin
      // A typed-in result overrides the evaluator copy for this expression
      if (typed_armed) begin
        res         = typed_result;
        typed_armed = 1'b0;
      end
      expected_q.push_back(res);
      exprs_sent++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_symbol(s[i]);
  endtask

  // Drop valid and hold off until every pending result has been taken
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SYM_W-1:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_PERCENT;
    endcase
  endfunction

  // Mostly a space; otherwise any other byte that is neither digit,
  // operator nor zero
  function automatic logic [SYM_W-1:0] pick_separator();
    logic [SYM_W-1:0] c;
    if ($urandom_range(0, 3) != 0) return " ";
    do c = SYM_W'($urandom_range(1, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) ||
           c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT});
    return c;
  endfunction

  // Operands lean small, with zero, the sign boundary, all ones, full-range
  // values, numbers past 32 bits and leading zeros mixed in
  function automatic string pick_operand();
    case ($urandom_range(0, 15))
      0:       return "0";
      1:       return "2147483648";
      2:       return "4294967295";
      3:       return $sformatf("%0d", $urandom);
      4:       return $sformatf("%0d%0d", $urandom, $urandom_range(0, 99999));
      5:       return $sformatf("00%0d", $urandom_range(0, 9));
      6, 7:    return $sformatf("%0d", $urandom_range(0, 20));
      default: return $sformatf("%0d", $urandom_range(0, 999));
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: change the stall pattern after each random span - always
  // ready, light stalls, coin toss, or ready only when the tick is a multiple of sixteen
  // -------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    int tick;
    out_ready_i = 1'b0;
    tick        = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          2:       out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= (tick % 16 == 0);
        endcase
      end
    end
  end

  // Check every accepted result against the oldest pending one
  always @(posedge clk_i) begin
    expr_result_t oldest;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d status %0d", value_o, status_o);
        error_count++;
      end else begin
        oldest = expected_q.pop_front();
        results_checked++;
        status_seen[status_o]++;
        if (value_o !== oldest.value) begin
          $error("value mismatch: expected %0d, actual %0d",
                 $signed(oldest.value), value_o);
          error_count++;
        end
        if (status_o !== oldest.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest.status, status_o);
          error_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int  kind;
    int  count;
    int  operands_left;
    int  depth;
    bit  prev_number;
    in_valid_i  = 1'b0;
    symbol_i    = CH_NUL;
    rst_ni      = 1'b0;
    typed_armed = 1'b0;
    burst_left  = 0;
    model_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_text(dir_text[r]);
      if (dir_typed[r]) begin
        typed_armed  = 1'b1;
        typed_result = dir_result[r];
      end
      send_symbol(CH_NUL);
    end
    drain_results();

    // Random expressions until enough characters have gone in
    while (symbols_sent < RANDOM_TARGET) begin
      kind        = $urandom_range(0, 99);
      prev_number = 1'b0;
      if (exprs_sent % 30 == 15) begin
        // Fill the stack to around its depth so the overflow path is hit
        count = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6);
        for (int i = 0; i < count; i++) begin
          if (prev_number) send_symbol(pick_separator());
          send_text($sformatf("%0d", $urandom_range(0, 99)));
          prev_number = 1'b1;
        end
        repeat ($urandom_range(0, 4)) send_symbol(pick_operator());
      end else if (kind < 70) begin
        // Well-formed: never let an operator see fewer than two values
        operands_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 4);
        depth         = 0;
        while (operands_left > 0 || depth > 1) begin
          if (operands_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
            if (prev_number) send_symbol(pick_separator());
            send_text(pick_operand());
            operands_left--;
            depth++;
            prev_number = 1'b1;
          end else begin
            if (prev_number && $urandom_range(0, 2) == 0) send_symbol(pick_separator());
            send_symbol(pick_operator());
            depth--;
            prev_number = 1'b0;
          end
        end
      end else if (kind < 85) begin
        // Broken: operators and operands in any order
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 1) == 1) begin
            send_symbol(pick_operator());
            prev_number = 1'b0;
          end else begin
            if (prev_number) send_symbol(pick_separator());
            send_text(pick_operand());
            prev_number = 1'b1;
          end
        end
      end else begin
        // Noise: any nonzero byte
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++) send_symbol(SYM_W'($urandom_range(1, 255)));
      end
      send_symbol(CH_NUL);
      // Now and then let the pipeline run dry before carrying on
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      error_count++;
    end

    $display("Ran %0d characters in %0d expressions; %0d results checked",
             symbols_sent, exprs_sent, results_checked);
    $display("Outcomes: ok %0d, underflow %0d, div by zero %0d, overflow %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_DIVZERO],
             status_seen[ST_OVERFLOW], status_seen[ST_EMPTY]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $error("run timed out");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pfx_pkg.sv
rtl/core/pfx_div.sv
rtl/core/pfx_dp.sv
rtl/core/pfx_ctrl.sv
rtl/core/postfix_expression_evaluator_top.sv
tb/postfix_expression_evaluator_top_test.sv
